// ----- hdl/iss_pkg.sv -----
`default_nettype none

package iss_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PTR_W   = 7;
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int FOUND_W = 7;

  localparam logic [PTR_W-1:0]          CAP_RESET = PTR_W'(DEPTH);
  localparam logic [PTR_W-1:0]          DEPTH_PTR = PTR_W'(DEPTH);
  localparam logic signed [FOUND_W-1:0] NOT_FOUND = '1;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } iss_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } iss_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // a word is accepted this cycle
    logic capture;  // latch the read data as the result word
    logic scan;     // compare one entry of the search walk
    logic finish;   // load the output register
  } iss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             empty;
    logic             match;
    logic             scan_last;
    logic             out_free;
  } iss_stat_t;

endpackage

`default_nettype wire

// ----- hdl/iss_if.sv -----
`default_nettype none

interface iss_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [iss_pkg::CMD_W-1:0]            command;
  logic signed [iss_pkg::WORD_W-1:0]    value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface iss_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 status;
  logic signed [iss_pkg::WORD_W-1:0]    data;
  logic signed [iss_pkg::FOUND_W-1:0]   found_index;
  logic [iss_pkg::PTR_W-1:0]            count;
  logic                                 is_empty;
  logic                                 is_full;

  modport source (output valid, output status, output data, output found_index,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data, input found_index,
                  input count, input is_empty, input is_full, output ready);
endinterface

interface iss_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [iss_pkg::PTR_W-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ----- hdl/iss_ram.sv -----
`default_nettype none

module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/iss_ctrl.sv -----
`default_nettype none

module iss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire iss_pkg::iss_stat_t stat,
  output iss_pkg::iss_cmd_t      cmd
);

  iss_pkg::iss_state_t state_r, state_nxt;
  logic take;

  assign take = in_valid && (state_r == iss_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iss_pkg::ST_IDLE: begin
        if (take) begin
          unique case (iss_pkg::iss_op_t'(stat.op))
            iss_pkg::OP_POP, iss_pkg::OP_PEEK:
              state_nxt = stat.empty ? iss_pkg::ST_DONE : iss_pkg::ST_READ;
            iss_pkg::OP_SEARCH:
              state_nxt = stat.empty ? iss_pkg::ST_DONE : iss_pkg::ST_SCAN;
            default:
              state_nxt = iss_pkg::ST_DONE;
          endcase
        end
      end
      iss_pkg::ST_READ: state_nxt = iss_pkg::ST_DONE;
      iss_pkg::ST_SCAN: begin
        if (stat.match || stat.scan_last) begin
          state_nxt = iss_pkg::ST_DONE;
        end
      end
      iss_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = iss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == iss_pkg::ST_IDLE);
    cmd.take    = take;
    cmd.capture = (state_r == iss_pkg::ST_READ);
    cmd.scan    = (state_r == iss_pkg::ST_SCAN);
    cmd.finish  = (state_r == iss_pkg::ST_DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_read_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iss_pkg::ST_READ) |=> (state_r == iss_pkg::ST_DONE))
    else $error("read state not followed by result state");

  a_empty_search_short: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stat.empty) |=> (state_r == iss_pkg::ST_DONE))
    else $error("command on empty stack did not go straight to result");

endmodule

`default_nettype wire

// ----- hdl/iss_dp.sv -----
`default_nettype none

module iss_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire iss_pkg::iss_cmd_t                   cmd,
  output iss_pkg::iss_stat_t                       stat,
  input  wire logic [iss_pkg::CMD_W-1:0]           in_command,
  input  wire logic signed [iss_pkg::WORD_W-1:0]   in_value,
  input  wire logic                                cfg_we,
  input  wire logic [iss_pkg::PTR_W-1:0]           cfg_capacity,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic                                     out_status,
  output logic signed [iss_pkg::WORD_W-1:0]        out_data,
  output logic signed [iss_pkg::FOUND_W-1:0]       out_found_index,
  output logic [iss_pkg::PTR_W-1:0]                out_count,
  output logic                                     out_is_empty,
  output logic                                     out_is_full
);

  logic [iss_pkg::PTR_W-1:0]          sp_r, sp_nxt;
  logic [iss_pkg::PTR_W-1:0]          cap_r;
  logic [iss_pkg::PTR_W-1:0]          cap_eff;
  logic [iss_pkg::ADDR_W-1:0]         scan_r;
  logic [iss_pkg::WORD_W-1:0]         val_r;
  logic                               status_r;
  logic [iss_pkg::WORD_W-1:0]         data_r;
  logic signed [iss_pkg::FOUND_W-1:0] found_r;
  logic                               out_valid_r;
  logic                               empty, full;
  logic                               ram_we;
  logic [iss_pkg::ADDR_W-1:0]         raddr;
  logic [iss_pkg::WORD_W-1:0]         rdata;
  iss_pkg::iss_op_t                   op;

  assign op      = iss_pkg::iss_op_t'(in_command);
  assign cap_eff = (cap_r > iss_pkg::DEPTH_PTR) ? iss_pkg::DEPTH_PTR : cap_r;
  assign empty   = (sp_r == '0);
  assign full    = (sp_r >= cap_eff);
  assign ram_we  = cmd.take && (op == iss_pkg::OP_PUSH) && !full;
  assign raddr   = cmd.scan ? (scan_r - 1'b1)
                            : iss_pkg::ADDR_W'(sp_r - 1'b1);

  assign stat.op        = in_command;
  assign stat.empty     = empty;
  assign stat.match     = (rdata == val_r);
  assign stat.scan_last = (scan_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  iss_ram #(
    .WIDTH (iss_pkg::WORD_W),
    .DEPTH (iss_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_r[iss_pkg::ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.take) begin
      unique case (op)
        iss_pkg::OP_PUSH:  if (!full)  sp_nxt = sp_r + 1'b1;
        iss_pkg::OP_POP:   if (!empty) sp_nxt = sp_r - 1'b1;
        iss_pkg::OP_CLEAR: sp_nxt = '0;
        default:           sp_nxt = sp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      cap_r       <= iss_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working result of the command in flight.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      val_r    <= in_value;
      scan_r   <= iss_pkg::ADDR_W'(sp_r - 1'b1);
      data_r   <= '0;
      found_r  <= iss_pkg::NOT_FOUND;
      status_r <= ((op == iss_pkg::OP_PUSH) && full) ||
                  (((op == iss_pkg::OP_POP) || (op == iss_pkg::OP_PEEK)) && empty);
    end
    if (cmd.capture) begin
      data_r <= rdata;
    end
    if (cmd.scan) begin
      if (rdata == val_r) begin
        found_r <= $signed(iss_pkg::FOUND_W'(scan_r));
      end else begin
        scan_r <= scan_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status      <= status_r;
      out_data        <= data_r;
      out_found_index <= found_r;
      out_count       <= sp_r;
      out_is_empty    <= empty;
      out_is_full     <= full;
    end
  end

  assign out_valid = out_valid_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= iss_pkg::DEPTH_PTR)
    else $error("stack pointer beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (sp_r == $past(sp_r) + 1'b1))
    else $error("successful push did not advance the pointer");

  a_found_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_found_index != iss_pkg::NOT_FOUND)) |->
      (iss_pkg::PTR_W'(out_found_index) < out_count))
    else $error("search index not below count");

endmodule

`default_nettype wire

// ----- hdl/integer_stack_with_search_top.sv -----
// From idle, push, clear, unknown and failed commands go straight to the result state;
// a pop or peek that succeeds passes through the read state first, a search through the scan state.
// The next word is accepted once the controller is back in idle, so no word is taken while one is
// still in work, and the controller leaves its result state only when the output register is free.
// A search walks the store through its single read port, one entry per cycle, from the top down.
// Reset (rst_n low, synchronous) empties the stack, sets capacity to 64 and drops out valid;
// the store itself is not cleared, since entries above the pointer are never read.
`default_nettype none

module integer_stack_with_search_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  iss_in_if.sink     in_ch,
  iss_out_if.source  out_ch,
  iss_cfg_if.sink    cfg_ch
);

  // Command and status between the sequencer and the datapath.
  iss_pkg::iss_cmd_t  cmd;
  iss_pkg::iss_stat_t stat;
  logic               in_ready;

  // The configuration word is a plain register load; user must write it only while idle (not enforced).
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // The controller owns the input handshake and sequences each command: pop and peek
  // wait in the read state for the registered read, search loops in its scan state.
  iss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the pointer, capacity, the store and the output register.
  // The output register lets a new word be accepted while a result still waits.
  iss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_value        (in_ch.value),
    .cfg_we          (cfg_ch.valid),
    .cfg_capacity    (cfg_ch.capacity),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_data        (out_ch.data),
    .out_found_index (out_ch.found_index),
    .out_count       (out_ch.count),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full)
  );

endmodule

`default_nettype wire
